/* src/ptc_pkg.sv */
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared constants for the pressure/temperature compensation pipeline:
// register indexes, adjustment modes, datapath constants and pipeline depth.
// ----------------------------------------------------------------------------
package ptc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_TEMP_COEFFS   = 3'd0;
  localparam logic [2:0] REG_PRES_COEFFS_A = 3'd1;
  localparam logic [2:0] REG_PRES_COEFFS_B = 3'd2;
  localparam logic [2:0] REG_PRES_COEFFS_C = 3'd3;
  localparam logic [2:0] REG_ADJUST_MODE   = 3'd4;
  localparam logic [2:0] REG_PRES_OFFSET   = 3'd5;
  localparam logic [2:0] REG_PRES_SCALE    = 3'd6;

  // Adjustment modes
  localparam logic ADJ_OFFSET = 1'b0;
  localparam logic ADJ_SCALE  = 1'b1;

  // Q2.14 unity, reset value of the scale register
  localparam logic [15:0] SCALE_ONE = 16'd16384;

  // Saturation limit of the Q18.8 pressure result
  localparam logic [25:0] PQ8_MAX = 26'h3FF_FFFF;

  // Fine temperature bias used by the pressure polynomial
  localparam logic signed [24:0] T_FINE_BIAS = 25'sd128000;

  // Numerator scale of the pressure division
  localparam logic [11:0] DIV_MULT = 12'd3125;

  // Offset added ahead of the divisor product (2^47)
  localparam logic [63:0] DEN_BIAS = 64'h0000_8000_0000_0000;

  // One restoring step per stage, one quotient bit each
  localparam int DIV_STAGES = 64;

  // Edges from the accepting edge to the edge that samples done high
  localparam int PIPE_LATENCY = 85;

endpackage

/* src/pressure_temperature_compensation_top.sv */
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_top
// Pipeline: start passes 12 front stages, 64 divider stages, 8 back
//   stages and 1 output register before done rises; the 64-bit divider
//   makes up most of that depth.
// Throughput: one transaction per clock while busy is low; start may be
//   high every cycle; the receiver cannot stall, results leave on the strobe.
// Reset: synchronous rst flushes all stage valid bits and the done strobe,
//   loads the register defaults; busy is high while rst is applied.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_top (
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic [19:0] raw_pressure,
  input  logic [19:0] raw_temperature,
  // register write port
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [47:0] wr_data,
  // result side
  output logic                done,
  output logic signed [15:0]  temperature_centi,
  output logic [25:0]         pressure_q8,
  output logic                divide_fault
);

  localparam logic signed [41:0] OSUM_MAX = 42'sd67108863;

  // --------------------------------------------------------------------------
  // Configuration registers: user must write only with pipe empty, not enforced
  // --------------------------------------------------------------------------
  logic [47:0]        temp_coeffs;
  logic [47:0]        pres_coeffs_a;
  logic [47:0]        pres_coeffs_b;
  logic [47:0]        pres_coeffs_c;
  logic               adjust_mode;
  logic signed [18:0] pressure_offset;
  logic [15:0]        pressure_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs     <= '0;
      pres_coeffs_a   <= '0;
      pres_coeffs_b   <= '0;
      pres_coeffs_c   <= '0;
      adjust_mode     <= ptc_pkg::ADJ_OFFSET;
      pressure_offset <= '0;
      pressure_scale  <= ptc_pkg::SCALE_ONE;
    end else if (wr_en) begin
      case (wr_index)
        ptc_pkg::REG_TEMP_COEFFS:   temp_coeffs     <= wr_data;
        ptc_pkg::REG_PRES_COEFFS_A: pres_coeffs_a   <= wr_data;
        ptc_pkg::REG_PRES_COEFFS_B: pres_coeffs_b   <= wr_data;
        ptc_pkg::REG_PRES_COEFFS_C: pres_coeffs_c   <= wr_data;
        ptc_pkg::REG_ADJUST_MODE:   adjust_mode     <= wr_data[0];
        ptc_pkg::REG_PRES_OFFSET:   pressure_offset <= $signed(wr_data[18:0]);
        ptc_pkg::REG_PRES_SCALE:    pressure_scale  <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  // Coefficient fields
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_coeffs[15:0];
  assign t2 = $signed(temp_coeffs[31:16]);
  assign t3 = $signed(temp_coeffs[47:32]);
  assign p1 = pres_coeffs_a[15:0];
  assign p2 = $signed(pres_coeffs_a[31:16]);
  assign p3 = $signed(pres_coeffs_a[47:32]);
  assign p4 = $signed(pres_coeffs_b[15:0]);
  assign p5 = $signed(pres_coeffs_b[31:16]);
  assign p6 = $signed(pres_coeffs_b[47:32]);
  assign p7 = $signed(pres_coeffs_c[15:0]);
  assign p8 = $signed(pres_coeffs_c[31:16]);
  assign p9 = $signed(pres_coeffs_c[47:32]);

  // busy only covers reset; the pipe itself never refuses a transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  logic accept;
  assign accept = start & ~busy;

  // --------------------------------------------------------------------------
  // Valid chain of the front and back stages
  // --------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  logic s7_valid, s8_valid, s9_valid, s10_valid, s11_valid;
  logic s13_valid, s14_valid, s15_valid, s16_valid, s17_valid;
  logic s18_valid, s19_valid, s20_valid;

  // Divider stage arrays; entry 0 is the stage that loads the divider
  logic [63:0]        dv_acc   [0:ptc_pkg::DIV_STAGES];
  logic [29:0]        dv_rem   [0:ptc_pkg::DIV_STAGES];
  logic [30:0]        dv_mb    [0:ptc_pkg::DIV_STAGES];
  logic               dv_neg   [0:ptc_pkg::DIV_STAGES];
  logic               dv_fault [0:ptc_pkg::DIV_STAGES];
  logic signed [15:0] dv_tc    [0:ptc_pkg::DIV_STAGES];
  logic               dv_valid [0:ptc_pkg::DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      s4_valid    <= 1'b0;
      s5_valid    <= 1'b0;
      s6_valid    <= 1'b0;
      s7_valid    <= 1'b0;
      s8_valid    <= 1'b0;
      s9_valid    <= 1'b0;
      s10_valid   <= 1'b0;
      s11_valid   <= 1'b0;
      dv_valid[0] <= 1'b0;
      s13_valid   <= 1'b0;
      s14_valid   <= 1'b0;
      s15_valid   <= 1'b0;
      s16_valid   <= 1'b0;
      s17_valid   <= 1'b0;
      s18_valid   <= 1'b0;
      s19_valid   <= 1'b0;
      s20_valid   <= 1'b0;
      done        <= 1'b0;
    end else begin
      s1_valid    <= accept;
      s2_valid    <= s1_valid;
      s3_valid    <= s2_valid;
      s4_valid    <= s3_valid;
      s5_valid    <= s4_valid;
      s6_valid    <= s5_valid;
      s7_valid    <= s6_valid;
      s8_valid    <= s7_valid;
      s9_valid    <= s8_valid;
      s10_valid   <= s9_valid;
      s11_valid   <= s10_valid;
      dv_valid[0] <= s11_valid;
      s13_valid   <= dv_valid[ptc_pkg::DIV_STAGES];
      s14_valid   <= s13_valid;
      s15_valid   <= s14_valid;
      s16_valid   <= s15_valid;
      s17_valid   <= s16_valid;
      s18_valid   <= s17_valid;
      s19_valid   <= s18_valid;
      s20_valid   <= s19_valid;
      done        <= s20_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1-5: temperature compensation
  // --------------------------------------------------------------------------
  logic signed [17:0] s1_d1;       // adc_t/8 - 2*T1
  logic signed [16:0] s1_d2;       // adc_t/16 - T1
  logic [20:0]        s1_pp0;      // 2^20 - adc_p, always 1..2^20

  logic signed [33:0] s2_m1;       // d1*T2
  logic [31:0]        s2_sq;       // d2^2, never negative, below 2^32
  logic [20:0]        s2_pp0;
  logic signed [33:0] sq_full;

  logic signed [22:0] s3_at;
  logic signed [36:0] s3_m3;       // (d2^2 >> 12) * T3
  logic [20:0]        s3_pp0;

  logic signed [23:0] s4_tf;       // fine temperature
  logic [20:0]        s4_pp0;

  logic signed [15:0] s5_tc;
  logic signed [24:0] s5_pa;       // tf - 128000
  logic [20:0]        s5_pp0;
  logic signed [26:0] tf5;
  logic signed [18:0] tr;
  logic signed [15:0] tc_next;

  assign sq_full = 34'(s1_d2) * 34'(s1_d2);
  assign tf5     = 27'(s4_tf) * 27'sd5 + 27'sd128;
  assign tr      = 19'(tf5 >>> 8);

  always_comb begin
    if (tr > 19'sd32767) begin
      tc_next = 16'sh7FFF;
    end else if (tr < -19'sd32768) begin
      tc_next = 16'sh8000;
    end else begin
      tc_next = tr[15:0];
    end
  end

  always_ff @(posedge clk) begin
    s1_d1  <= $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    s1_d2  <= $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
    s1_pp0 <= 21'h10_0000 - {1'b0, raw_pressure};

    s2_m1  <= 34'(s1_d1) * 34'(t2);
    s2_sq  <= sq_full[31:0];
    s2_pp0 <= s1_pp0;

    s3_at  <= 23'(s2_m1 >>> 11);
    s3_m3  <= 37'($signed({1'b0, s2_sq[31:12]})) * 37'(t3);
    s3_pp0 <= s2_pp0;

    s4_tf  <= 24'(s3_at) + 24'(s3_m3 >>> 14);
    s4_pp0 <= s3_pp0;

    s5_tc  <= tc_next;
    s5_pa  <= 25'(s4_tf) - ptc_pkg::T_FINE_BIAS;
    s5_pp0 <= s4_pp0;
  end

  // --------------------------------------------------------------------------
  // Stages 6-12: pressure polynomial, numerator and divisor
  // All wide terms wrap modulo 2^64; products with a 64-bit operand split into 32-bit halves.
  // --------------------------------------------------------------------------
  logic signed [49:0] s6_asq;
  logic signed [40:0] s6_m5, s6_a2p;
  logic signed [15:0] s6_tc;
  logic [20:0]        s6_pp0;

  logic signed [63:0] s7_bp6, s7_bp3;
  logic signed [40:0] s7_m5, s7_a2p;
  logic signed [15:0] s7_tc;
  logic [20:0]        s7_pp0;
  logic signed [65:0] bp6_full, bp3_full;

  logic signed [63:0] s8_bsum, s8_a2;
  logic signed [15:0] s8_tc;
  logic [20:0]        s8_pp0;

  logic [47:0]        s9_dlo;
  logic [31:0]        s9_dhi;
  logic [63:0]        s9_num0;
  logic signed [15:0] s9_tc;
  logic [63:0]        xden;
  logic [47:0]        dhi_full;

  logic signed [30:0] s10_den;
  logic [43:0]        s10_nlo;
  logic [31:0]        s10_nhi;
  logic signed [15:0] s10_tc;
  logic [63:0]        dprod;
  logic [43:0]        nhi_full;

  logic [63:0]        s11_num;
  logic signed [30:0] s11_den;
  logic signed [15:0] s11_tc;

  assign bp6_full = 66'(s6_asq) * 66'(p6);
  assign bp3_full = 66'(s6_asq) * 66'(p3);
  assign xden     = ptc_pkg::DEN_BIAS + $unsigned(s8_a2);
  assign dhi_full = 48'(xden[63:32]) * 48'(p1);
  assign dprod    = 64'(s9_dlo) + {s9_dhi, 32'd0};
  assign nhi_full = 44'(s9_num0[63:32]) * 44'(ptc_pkg::DIV_MULT);

  always_ff @(posedge clk) begin
    s6_asq  <= 50'(s5_pa) * 50'(s5_pa);
    s6_m5   <= 41'(s5_pa) * 41'(p5);
    s6_a2p  <= 41'(s5_pa) * 41'(p2);
    s6_tc   <= s5_tc;
    s6_pp0  <= s5_pp0;

    s7_bp6  <= bp6_full[63:0];
    s7_bp3  <= bp3_full[63:0];
    s7_m5   <= s6_m5;
    s7_a2p  <= s6_a2p;
    s7_tc   <= s6_tc;
    s7_pp0  <= s6_pp0;

    s8_bsum <= s7_bp6 + (64'(s7_m5) <<< 17) + (64'(p4) <<< 35);
    s8_a2   <= (s7_bp3 >>> 8) + (64'(s7_a2p) <<< 12);
    s8_tc   <= s7_tc;
    s8_pp0  <= s7_pp0;

    s9_dlo  <= 48'(xden[31:0]) * 48'(p1);
    s9_dhi  <= dhi_full[31:0];
    s9_num0 <= 64'({s8_pp0, 31'd0}) - $unsigned(s8_bsum);
    s9_tc   <= s8_tc;

    s10_den <= $signed(dprod[63:33]);
    s10_nlo <= 44'(s9_num0[31:0]) * 44'(ptc_pkg::DIV_MULT);
    s10_nhi <= nhi_full[31:0];
    s10_tc  <= s9_tc;

    s11_num <= 64'(s10_nlo) + {s10_nhi, 32'd0};
    s11_den <= s10_den;
    s11_tc  <= s10_tc;

    // divider load: magnitudes, quotient sign, zero-divisor flag
    dv_acc[0]   <= s11_num[63] ? (64'd0 - s11_num) : s11_num;
    dv_rem[0]   <= '0;
    dv_mb[0]    <= s11_den[30] ? (31'd0 - $unsigned(s11_den)) : $unsigned(s11_den);
    dv_neg[0]   <= s11_num[63] ^ s11_den[30];
    dv_fault[0] <= (s11_den == 31'sd0);
    dv_tc[0]    <= s11_tc;
  end

  // --------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage. The accumulator shifts the
  // dividend out at the top and the quotient bits in at the bottom.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < ptc_pkg::DIV_STAGES; k++) begin : g_div
    logic [30:0] trial;
    logic        ge;

    assign trial = {dv_rem[k], dv_acc[k][63]};
    assign ge    = (trial >= dv_mb[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      dv_rem[k+1]   <= ge ? 30'(trial - dv_mb[k]) : trial[29:0];
      dv_acc[k+1]   <= {dv_acc[k][62:0], ge};
      dv_mb[k+1]    <= dv_mb[k];
      dv_neg[k+1]   <= dv_neg[k];
      dv_fault[k+1] <= dv_fault[k];
      dv_tc[k+1]    <= dv_tc[k];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 13-19: quotient sign, P8/P9 correction terms, P7 offset
  // --------------------------------------------------------------------------
  logic [63:0]        s13_pp;
  logic               s13_fault;
  logic signed [15:0] s13_tc;

  logic [63:0]        s14_pl;      // low half squared
  logic [31:0]        s14_cr;      // cross term, low word
  logic signed [48:0] s14_ul;      // low word of pp times P8
  logic [31:0]        s14_uh;
  logic [63:0]        s14_pp;
  logic               s14_fault;
  logic signed [15:0] s14_tc;
  logic signed [63:0] x13;
  logic [63:0]        cr_full;
  logic signed [48:0] uh_full;

  logic [63:0]        s15_sq2;     // (pp>>>13)^2 mod 2^64
  logic signed [63:0] s15_b8;      // pp*P8 mod 2^64
  logic [63:0]        s15_pp;
  logic               s15_fault;
  logic signed [15:0] s15_tc;

  logic signed [48:0] s16_sl;
  logic [31:0]        s16_sh;
  logic signed [63:0] s16_b8;
  logic [63:0]        s16_pp;
  logic               s16_fault;
  logic signed [15:0] s16_tc;
  logic signed [48:0] sh_full;

  logic signed [63:0] s17_a9;      // P9 * sq2 mod 2^64
  logic signed [63:0] s17_b8;
  logic [63:0]        s17_pp;
  logic               s17_fault;
  logic signed [15:0] s17_tc;

  logic signed [63:0] s18_sum;
  logic               s18_fault;
  logic signed [15:0] s18_tc;

  logic signed [63:0] s19_pv;
  logic               s19_fault;
  logic signed [15:0] s19_tc;

  assign x13     = $signed(s13_pp) >>> 13;
  assign cr_full = 64'(x13[31:0]) * 64'(x13[63:32]);
  assign uh_full = 49'($signed({1'b0, s13_pp[63:32]})) * 49'(p8);
  assign sh_full = 49'($signed({1'b0, s15_sq2[63:32]})) * 49'(p9);

  always_ff @(posedge clk) begin
    s13_pp    <= dv_neg[ptc_pkg::DIV_STAGES] ? (64'd0 - dv_acc[ptc_pkg::DIV_STAGES])
                                             : dv_acc[ptc_pkg::DIV_STAGES];
    s13_fault <= dv_fault[ptc_pkg::DIV_STAGES];
    s13_tc    <= dv_tc[ptc_pkg::DIV_STAGES];

    s14_pl    <= 64'(x13[31:0]) * 64'(x13[31:0]);
    s14_cr    <= cr_full[31:0];
    s14_ul    <= 49'($signed({1'b0, s13_pp[31:0]})) * 49'(p8);
    s14_uh    <= uh_full[31:0];
    s14_pp    <= s13_pp;
    s14_fault <= s13_fault;
    s14_tc    <= s13_tc;

    s15_sq2   <= s14_pl + {s14_cr[30:0], 33'd0};
    s15_b8    <= 64'(s14_ul) + $signed({s14_uh, 32'd0});
    s15_pp    <= s14_pp;
    s15_fault <= s14_fault;
    s15_tc    <= s14_tc;

    s16_sl    <= 49'($signed({1'b0, s15_sq2[31:0]})) * 49'(p9);
    s16_sh    <= sh_full[31:0];
    s16_b8    <= s15_b8;
    s16_pp    <= s15_pp;
    s16_fault <= s15_fault;
    s16_tc    <= s15_tc;

    s17_a9    <= 64'(s16_sl) + $signed({s16_sh, 32'd0});
    s17_b8    <= s16_b8;
    s17_pp    <= s16_pp;
    s17_fault <= s16_fault;
    s17_tc    <= s16_tc;

    s18_sum   <= $signed(s17_pp) + (s17_a9 >>> 25) + (s17_b8 >>> 19);
    s18_fault <= s17_fault;
    s18_tc    <= s17_tc;

    s19_pv    <= (s18_sum >>> 8) + (64'(p7) <<< 4);
    s19_fault <= s18_fault;
    s19_tc    <= s18_tc;
  end

  // --------------------------------------------------------------------------
  // Stage 20: adjustment terms; output stage: select and saturate
  // --------------------------------------------------------------------------
  logic               s20_mode;
  logic               s20_big_pos;  // pv >= 2^40
  logic               s20_big_neg;  // pv < -2^40 (the edge value clamps anyway)
  logic               s20_neg;
  logic               s20_zscale;
  logic signed [41:0] s20_osum;
  logic [55:0]        s20_prod;
  logic               s20_fault;
  logic signed [15:0] s20_tc;
  logic [25:0]        res;

  always_ff @(posedge clk) begin
    s20_mode    <= adjust_mode;
    s20_big_pos <= !s19_pv[63] && (|s19_pv[62:40]);
    s20_big_neg <= s19_pv[63] && !(&s19_pv[62:40]);
    s20_neg     <= s19_pv[63];
    s20_zscale  <= (pressure_scale == 16'd0);
    s20_osum    <= 42'($signed(s19_pv[40:0])) + 42'(pressure_offset);
    s20_prod    <= 56'(s19_pv[39:0]) * 56'(pressure_scale);
    s20_fault   <= s19_fault;
    s20_tc      <= s19_tc;
  end

  always_comb begin
    if (s20_fault) begin
      res = '0;
    end else if (s20_mode == ptc_pkg::ADJ_OFFSET) begin
      if (s20_big_pos) begin
        res = ptc_pkg::PQ8_MAX;
      end else if (s20_big_neg || s20_osum < 42'sd0) begin
        res = '0;
      end else if (s20_osum > OSUM_MAX) begin
        res = ptc_pkg::PQ8_MAX;
      end else begin
        res = s20_osum[25:0];
      end
    end else begin
      if (s20_neg || s20_zscale) begin
        res = '0;
      end else if (s20_big_pos || (|s20_prod[55:40])) begin
        res = ptc_pkg::PQ8_MAX;
      end else begin
        res = s20_prod[39:14];
      end
    end
  end

  always_ff @(posedge clk) begin
    temperature_centi <= s20_tc;
    pressure_q8       <= res;
    divide_fault      <= s20_fault;
  end

endmodule

/* src/ptc_checker.sv */
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks on the compensation pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module ptc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        divide_fault,
  input logic [25:0] pressure_q8
);

  // every result traces back to a transaction a fixed depth earlier
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, ptc_pkg::PIPE_LATENCY))
    else $error("result without matching transaction");

  // zero divisor forces the pressure result to zero
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (done && divide_fault) |-> (pressure_q8 == 26'd0))
    else $error("divide fault with nonzero pressure");

  // reset flushes the result strobe
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe after reset");

  // busy drops once reset is released
  a_busy_release: assert property (@(posedge clk)
    !rst |=> !busy)
    else $error("busy held outside reset");

endmodule

bind pressure_temperature_compensation_top ptc_checker u_ptc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .divide_fault (divide_fault),
  .pressure_q8  (pressure_q8)
);
